// ===== rtl/core/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helper functions of the sensor compensation core.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] CFG_TEMP   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PRES_A = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PRES_B = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PRES_C = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_HUM    = 3'd4;

	localparam logic [1:0] FUNC_TEMP = 2'd0;
	localparam logic [1:0] FUNC_PRES = 2'd1;
	localparam logic [1:0] FUNC_HUM  = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic [31:0] HUM_MAX = 32'd419430400;

	typedef enum logic [5:0] {
		S_NOP,
		S_NONE,
		S_T0, S_T1, S_T2, S_T3, S_T4,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
		S_P9, S_P10, S_P11, S_P12, S_P13, S_P14, S_P15, S_P16,
		S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
		S_H9, S_H10, S_H11, S_H12
	} step_t;

	typedef struct packed {
		step_t step;
		logic  in_load;
		logic  out_load;
	} esc_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic v1_zero;
	} esc_sts_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		asr = 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		mul = p[31:0];
	endfunction

endpackage

// ===== rtl/core/env_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer compensation of temperature, pressure and humidity sensor readings.
// ----------------------------------------------------------------------------
// The result is registered once the formula's steps are done; a pressure formula also
// waits for the serial divider, and a zero divisor ends it before the divider starts.
// One transaction at a time: the next is accepted only once the result is loaded into
// the output register; the multiplier sequence and, for pressure, the divider wait set it.
// Asynchronous reset clears calibration registers, fine temperature and control.
module env_sensor_compensation_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [19:0]                   raw_adc,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            comp_value,
	output logic                          div_zero,
	input  logic                          cfg_we,
	input  logic [esc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [esc_pkg::CfgDataW-1:0]  cfg_data
);
	import esc_pkg::*;

	esc_cmd_t cmd;
	esc_sts_t sts;

	esc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	esc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.raw_adc    (raw_adc),
		.cmd        (cmd),
		.sts        (sts),
		.comp_value (comp_value),
		.div_zero   (div_zero)
	);

endmodule

// ===== rtl/core/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer that steps the datapath through one compensation formula.
// ----------------------------------------------------------------------------
module esc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	output logic             out_valid,
	input  logic             out_stall,
	output esc_pkg::esc_cmd_t cmd,
	input  esc_pkg::esc_sts_t sts
);
	import esc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_PUSH} state_t;

	state_t state_q;
	step_t  step_q;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;
	step_t  step_nxt;
	logic   last_step;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		last_step = 1'b0;
		step_nxt  = S_NOP;
		case (step_q)
			S_T0:  step_nxt = S_T1;
			S_T1:  step_nxt = S_T2;
			S_T2:  step_nxt = S_T3;
			S_T3:  step_nxt = S_T4;
			S_P0:  step_nxt = S_P1;
			S_P1:  step_nxt = S_P2;
			S_P2:  step_nxt = S_P3;
			S_P3:  step_nxt = S_P4;
			S_P4:  step_nxt = S_P5;
			S_P5:  step_nxt = S_P6;
			S_P6:  step_nxt = S_P7;
			S_P7:  step_nxt = S_P8;
			S_P8:  step_nxt = S_P9;
			S_P9:  step_nxt = S_P10;
			S_P10: begin
				if (sts.v1_zero) begin
					last_step = 1'b1;
				end else begin
					step_nxt = S_P11;
				end
			end
			S_P11: step_nxt = S_P12;
			S_P12: step_nxt = S_P13;
			S_P13: step_nxt = S_P14;
			S_P14: step_nxt = S_P15;
			S_P15: step_nxt = S_P16;
			S_H0:  step_nxt = S_H1;
			S_H1:  step_nxt = S_H2;
			S_H2:  step_nxt = S_H3;
			S_H3:  step_nxt = S_H4;
			S_H4:  step_nxt = S_H5;
			S_H5:  step_nxt = S_H6;
			S_H6:  step_nxt = S_H7;
			S_H7:  step_nxt = S_H8;
			S_H8:  step_nxt = S_H9;
			S_H9:  step_nxt = S_H10;
			S_H10: step_nxt = S_H11;
			S_H11: step_nxt = S_H12;
			default: last_step = 1'b1;
		endcase
	end

	always_comb begin
		cmd.step     = (state_q == ST_RUN) ? step_q : S_NOP;
		cmd.in_load  = in_acc;
		cmd.out_load = (state_q == ST_PUSH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= S_NOP;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						case (func)
							FUNC_TEMP: step_q <= S_T0;
							FUNC_PRES: step_q <= S_P0;
							FUNC_HUM:  step_q <= S_H0;
							default:   step_q <= S_NONE;
						endcase
					end
				end
				ST_RUN: begin
					if (last_step) begin
						state_q <= ST_PUSH;
					end else if (step_q == S_P11) begin
						state_q <= ST_DIV;
						step_q  <= step_nxt;
					end else begin
						step_q <= step_nxt;
					end
				end
				ST_DIV: begin
					if (!sts.div_busy) begin
						state_q <= ST_RUN;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An accepted transaction always starts a formula.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_RUN)
		else $error("accepted transaction did not start");

	// The result register is never overwritten while a transaction waits in it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

	// The divider wait is only entered right after the divider start step.
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DIV) |-> $past(step_q) == S_P11)
		else $error("divider wait entered from wrong step");

endmodule

// ===== rtl/core/esc_datapath.sv =====
// ----------------------------------------------------------------------------
// esc_datapath
// Calibration registers, working registers, one multiplier and a serial divider.
// ----------------------------------------------------------------------------
module esc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [esc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [esc_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [19:0]                   raw_adc,
	input  esc_pkg::esc_cmd_t             cmd,
	output esc_pkg::esc_sts_t             sts,
	output logic signed [31:0]            comp_value,
	output logic                          div_zero
);
	import esc_pkg::*;

	logic [47:0] cal_temp_q;
	logic [63:0] cal_pres_a_q;
	logic [63:0] cal_pres_b_q;
	logic [15:0] cal_pres_c_q;
	logic [63:0] cal_hum_q;
	logic [31:0] fine_q;

	logic [31:0] adc_q;
	logic [31:0] a_q, b_q, c_q, d_q, res_q;
	logic        dz_q;
	logic        hi_q;

	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        div_busy_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        q_bit;

	logic [31:0] t1, t2, t3;
	logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic [31:0] hclamp;

	assign t1 = {16'd0, cal_temp_q[15:0]};
	assign t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
	assign t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
	assign p1 = {16'd0, cal_pres_a_q[15:0]};
	assign p2 = {{16{cal_pres_a_q[31]}}, cal_pres_a_q[31:16]};
	assign p3 = {{16{cal_pres_a_q[47]}}, cal_pres_a_q[47:32]};
	assign p4 = {{16{cal_pres_a_q[63]}}, cal_pres_a_q[63:48]};
	assign p5 = {{16{cal_pres_b_q[15]}}, cal_pres_b_q[15:0]};
	assign p6 = {{16{cal_pres_b_q[31]}}, cal_pres_b_q[31:16]};
	assign p7 = {{16{cal_pres_b_q[47]}}, cal_pres_b_q[47:32]};
	assign p8 = {{16{cal_pres_b_q[63]}}, cal_pres_b_q[63:48]};
	assign p9 = {{16{cal_pres_c_q[15]}}, cal_pres_c_q};
	assign h1 = {24'd0, cal_hum_q[7:0]};
	assign h2 = {{16{cal_hum_q[23]}}, cal_hum_q[23:8]};
	assign h3 = {24'd0, cal_hum_q[31:24]};
	assign h4 = {{20{cal_hum_q[43]}}, cal_hum_q[43:32]};
	assign h5 = {{20{cal_hum_q[55]}}, cal_hum_q[55:44]};
	assign h6 = {{24{cal_hum_q[63]}}, cal_hum_q[63:56]};

	assign hclamp = a_q[31] ? 32'd0 : ((a_q > HUM_MAX) ? HUM_MAX : a_q);

	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, c_q};
	assign q_bit   = !rem_sub[32];

	assign sts.div_busy = div_busy_q;
	assign sts.v1_zero  = (c_q == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q   <= '0;
			cal_pres_a_q <= '0;
			cal_pres_b_q <= '0;
			cal_pres_c_q <= '0;
			cal_hum_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP:   cal_temp_q   <= cfg_data[47:0];
				CFG_PRES_A: cal_pres_a_q <= cfg_data;
				CFG_PRES_B: cal_pres_b_q <= cfg_data;
				CFG_PRES_C: cal_pres_c_q <= cfg_data[15:0];
				CFG_HUM:    cal_hum_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			cnt_q      <= '0;
		end else if (cmd.step == S_P11) begin
			div_busy_q <= 1'b1;
			cnt_q      <= 5'd31;
		end else if (div_busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step == S_P11) begin
			quo_q <= a_q[31] ? a_q : {a_q[30:0], 1'b0};
			rem_q <= '0;
			hi_q  <= a_q[31];
		end else if (div_busy_q) begin
			quo_q <= {quo_q[30:0], q_bit};
			rem_q <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
		end else if (cmd.step == S_T3) begin
			fine_q <= a_q + asr(b_q, 5'd14);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			adc_q <= {12'd0, raw_adc};
		end
		if (cmd.out_load) begin
			comp_value <= $signed(res_q);
			div_zero   <= dz_q;
		end
		case (cmd.step)
			S_NONE: begin
				res_q <= '0;
				dz_q  <= 1'b0;
			end
			S_T0: begin
				a_q <= mul((adc_q >> 3) - (t1 << 1), t2);
				d_q <= (adc_q >> 4) - t1;
			end
			S_T1: begin
				a_q <= asr(a_q, 5'd11);
				b_q <= mul(d_q, d_q);
			end
			S_T2: b_q <= mul(asr(b_q, 5'd12), t3);
			S_T4: begin
				res_q <= asr(mul(fine_q, 32'd5) + 32'd128, 5'd8);
				dz_q  <= 1'b0;
			end
			S_P0:  c_q <= asr(fine_q, 5'd1) - 32'd64000;
			S_P1:  a_q <= mul(asr(c_q, 5'd2), asr(c_q, 5'd2));
			S_P2:  b_q <= mul(asr(a_q, 5'd11), p6);
			S_P3:  d_q <= mul(c_q, p5);
			S_P4:  b_q <= asr(b_q + (d_q << 1), 5'd2) + (p4 << 16);
			S_P5:  d_q <= mul(p3, asr(a_q, 5'd13));
			S_P6:  a_q <= mul(p2, c_q);
			S_P7:  c_q <= asr(asr(d_q, 5'd3) + asr(a_q, 5'd1), 5'd18);
			S_P8:  c_q <= mul(32'd32768 + c_q, p1);
			S_P9:  c_q <= asr(c_q, 5'd15);
			S_P10: begin
				if (c_q == 32'd0) begin
					res_q <= '0;
					dz_q  <= 1'b1;
				end
				a_q <= mul((32'd1048576 - adc_q) - asr(b_q, 5'd12), 32'd3125);
			end
			S_P12: a_q <= hi_q ? {quo_q[30:0], 1'b0} : quo_q;
			S_P13: d_q <= mul(a_q >> 3, a_q >> 3);
			S_P14: d_q <= mul(p9, d_q >> 13);
			S_P15: b_q <= mul(a_q >> 2, p8);
			S_P16: begin
				res_q <= a_q + asr(asr(d_q, 5'd12) + asr(b_q, 5'd13) + p7, 5'd4);
				dz_q  <= 1'b0;
			end
			S_H0:  c_q <= fine_q - 32'd76800;
			S_H1:  a_q <= mul(h5, c_q);
			S_H2:  a_q <= asr((adc_q << 14) - (h4 << 20) - a_q + 32'd16384, 5'd15);
			S_H3:  b_q <= mul(c_q, h6);
			S_H4:  d_q <= mul(c_q, h3);
			S_H5:  b_q <= mul(asr(b_q, 5'd10), asr(d_q, 5'd11) + 32'd32768);
			S_H6:  b_q <= mul(asr(b_q, 5'd10) + 32'd2097152, h2);
			S_H7:  b_q <= asr(b_q + 32'd8192, 5'd14);
			S_H8:  a_q <= mul(a_q, b_q);
			S_H9:  d_q <= mul(asr(a_q, 5'd15), asr(a_q, 5'd15));
			S_H10: d_q <= mul(asr(d_q, 5'd7), h1);
			S_H11: a_q <= a_q - asr(d_q, 5'd4);
			S_H12: begin
				res_q <= hclamp >> 12;
				dz_q  <= 1'b0;
			end
			default: ;
		endcase
	end

	// The divider is never started with a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step == S_P11 |-> c_q != 32'd0)
		else $error("division started with zero divisor");

	// The divisor holds while the divider iterates.
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q && $past(div_busy_q) |-> $stable(c_q))
		else $error("divisor changed during division");

	// The divider finishes exactly when its count runs out.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(div_busy_q) |-> $past(cnt_q) == 5'd0)
		else $error("divider ended early");

endmodule

// ===== bench/env_sensor_compensation_checker.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation_checker
// Watches both channels and the calibration port of the compensation core,
// predicts every result from its own copy of the calibration and the fine
// temperature, and compares each output transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------
module env_sensor_compensation_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [19:0]                   raw_adc,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [31:0]            comp_value,
	input  logic                          div_zero,
	input  logic                          cfg_we,
	input  logic [esc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [esc_pkg::CfgDataW-1:0]  cfg_data,
	output int                            fail_count,
	output int                            pending
);
	import esc_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        dz;
	} reading_t;

	logic [47:0] k_temp;
	logic [63:0] k_pa, k_pb, k_hum;
	logic [15:0] k_pc;
	logic [31:0] t_fine;
	reading_t    expected_readings[$];

	assign pending = expected_readings.size();

	function automatic logic [31:0] sar(input logic [31:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] m32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	task automatic compensate(input logic [1:0] sel, input logic [31:0] adc,
			output reading_t r);
		logic [31:0] t1, t2, t3, a, b, d;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, q, p;
		logic [31:0] h1, h2, h3, h4, h5, h6, v, s;
		r = '0;
		case (sel)
			FUNC_TEMP: begin
				t1 = {16'd0, k_temp[15:0]};
				t2 = sx16(k_temp[31:16]);
				t3 = sx16(k_temp[47:32]);
				a = sar(m32(sar(adc, 3) - (t1 << 1), t2), 11);
				d = sar(adc, 4) - t1;
				b = sar(m32(sar(m32(d, d), 12), t3), 14);
				t_fine = a + b;
				r.value = sar(m32(t_fine, 32'd5) + 32'd128, 8);
			end
			FUNC_PRES: begin
				p1 = {16'd0, k_pa[15:0]};
				p2 = sx16(k_pa[31:16]);
				p3 = sx16(k_pa[47:32]);
				p4 = sx16(k_pa[63:48]);
				p5 = sx16(k_pb[15:0]);
				p6 = sx16(k_pb[31:16]);
				p7 = sx16(k_pb[47:32]);
				p8 = sx16(k_pb[63:48]);
				p9 = sx16(k_pc);
				v1 = sar(t_fine, 1) - 32'd64000;
				q = m32(sar(v1, 2), sar(v1, 2));
				v2 = m32(sar(q, 11), p6);
				v2 = v2 + (m32(v1, p5) << 1);
				v2 = sar(v2, 2) + (p4 << 16);
				v1 = sar(sar(m32(p3, sar(q, 13)), 3) + sar(m32(p2, v1), 1), 18);
				v1 = sar(m32(32'd32768 + v1, p1), 15);
				if (v1 == 0) begin
					r.dz = 1'b1;
				end else begin
					p = m32((32'd1048576 - adc) - sar(v2, 12), 32'd3125);
					if (p < 32'h8000_0000) p = (p << 1) / v1;
					else p = (p / v1) * 32'd2;
					v1 = sar(m32(p9, m32(p >> 3, p >> 3) >> 13), 12);
					v2 = sar(m32(p >> 2, p8), 13);
					r.value = p + sar(v1 + v2 + p7, 4);
				end
			end
			FUNC_HUM: begin
				h1 = {24'd0, k_hum[7:0]};
				h2 = sx16(k_hum[23:8]);
				h3 = {24'd0, k_hum[31:24]};
				h4 = {{20{k_hum[43]}}, k_hum[43:32]};
				h5 = {{20{k_hum[55]}}, k_hum[55:44]};
				h6 = {{24{k_hum[63]}}, k_hum[63:56]};
				v = t_fine - 32'd76800;
				a = sar((adc << 14) - (h4 << 20) - m32(h5, v) + 32'd16384, 15);
				b = sar(m32(sar(m32(v, h6), 10), sar(m32(v, h3), 11) + 32'd32768), 10)
					+ 32'd2097152;
				b = sar(m32(b, h2) + 32'd8192, 14);
				v = m32(a, b);
				s = sar(v, 15);
				v = v - sar(m32(sar(m32(s, s), 7), h1), 4);
				if (v[31]) v = 0;
				if (v > HUM_MAX) v = HUM_MAX;
				r.value = v >> 12;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t r, e;
		if (!arst_n) begin
			k_temp = '0; k_pa = '0; k_pb = '0; k_pc = '0; k_hum = '0;
			t_fine = '0;
			fail_count = 0;
			expected_readings.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TEMP:   k_temp = cfg_data[47:0];
					CFG_PRES_A: k_pa = cfg_data;
					CFG_PRES_B: k_pb = cfg_data;
					CFG_PRES_C: k_pc = cfg_data[15:0];
					CFG_HUM:    k_hum = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				compensate(func, {12'd0, raw_adc}, r);
				expected_readings.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected output transaction: comp_value %h", comp_value);
					fail_count++;
				end else begin
					e = expected_readings.pop_front();
					if (comp_value !== e.value) begin
						$error("comp_value expected %h actual %h", e.value, comp_value);
						fail_count++;
					end
					if (div_zero !== e.dz) begin
						$error("div_zero expected %b actual %b", e.dz, div_zero);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== bench/env_sensor_compensation_core_tb.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation_core_tb
// Drives calibration phases and directed and random readings into the
// compensation core with random idling on both channels and one long output
// hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core_tb;
	import esc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            func = '0;
	logic [19:0]           raw_adc = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [31:0]    comp_value;
	logic                  div_zero;
	logic                  cfg_we = 1'b0;
	logic [CfgIdxW-1:0]    cfg_index = '0;
	logic [CfgDataW-1:0]   cfg_data = '0;
	int                    fail_count, pending;
	int                    cycle = 0;
	int                    quiet_until = 0;
	int                    hold_left = 0;
	bit                    hold_done = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	env_sensor_compensation_core dut (.*);

	env_sensor_compensation_checker chk (.*);

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("env_sensor_compensation_core verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, a quiet stretch, and one long hold-off.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && cycle == 3000) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			out_stall <= 1'b1;
		end else if (cycle < quiet_until) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 16);
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input logic [1:0] f, input logic [19:0] adc);
		cfg_we <= 1'b0;
		while (cycle >= quiet_until && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		raw_adc <= adc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Typical sensor calibration so pressure and humidity land in range.
	task automatic write_typical();
		write_cal(CFG_TEMP, {16'd0, 16'sd50, 16'sd26435, 16'd27504});
		write_cal(CFG_PRES_A, {16'sd2855, -16'sd4361, 16'sd3024, 16'd36477});
		write_cal(CFG_PRES_B, {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140});
		write_cal(CFG_PRES_C, 64'd6000);
		write_cal(CFG_HUM, {8'd30, 12'd50, 12'd330, 8'd0, 16'd360, 8'd75});
	endtask

	task automatic random_items(input int n);
		int r;
		logic [19:0] adc;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			adc = (r % 7 == 0) ? 20'($urandom) : 20'($urandom_range(300000, 700000));
			if (r < 30) send(FUNC_TEMP, adc);
			else if (r < 65) send(FUNC_PRES, adc);
			else if (r < 96) send(FUNC_HUM, (r & 1) ? 20'($urandom_range(20000, 40000))
				: 20'($urandom));
			else send(FUNC_NONE, 20'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero calibration: zero divisor and pre-temperature reads.
		send(FUNC_PRES, 20'd500000);
		send(FUNC_HUM, 20'd30000);
		send(FUNC_NONE, 20'hFFFFF);
		drain();

		write_typical();
		send(FUNC_TEMP, 20'd519888);
		send(FUNC_PRES, 20'd415148);
		send(FUNC_HUM, 20'd30000);
		send(FUNC_TEMP, 20'd0);
		send(FUNC_PRES, 20'hFFFFF);
		send(FUNC_HUM, 20'hFFFFF);
		send(FUNC_HUM, 20'd0);
		send(FUNC_TEMP, 20'hFFFFF);
		send(FUNC_PRES, 20'd0);
		send(FUNC_HUM, 20'hFFFF);
		send(FUNC_NONE, 20'd0);
		send(FUNC_PRES, 20'd300000);
		drain();

		// All-ones and extreme calibration.
		write_cal(CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cal(CFG_PRES_A, 64'h7FFF_8000_7FFF_FFFF);
		write_cal(CFG_PRES_B, 64'h8000_7FFF_8000_7FFF);
		write_cal(CFG_PRES_C, 64'h8000);
		write_cal(CFG_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
		send(FUNC_TEMP, 20'hFFFFF);
		send(FUNC_PRES, 20'hFFFFF);
		send(FUNC_HUM, 20'hFFFFF);
		send(FUNC_PRES, 20'd0);
		drain();

		write_typical();
		quiet_until = cycle + 1500;
		random_items(200);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			write_cal(CFG_TEMP, rnd64());
			write_cal(CFG_PRES_A, rnd64());
			write_cal(CFG_PRES_B, rnd64());
			write_cal(CFG_PRES_C, rnd64());
			write_cal(CFG_HUM, rnd64());
			random_items(50);
			drain();
		end

		write_typical();
		random_items(100);
		drain();

		if (fail_count == 0) begin
			$display("env_sensor_compensation_core verification clean");
		end else begin
			$display("env_sensor_compensation_core verification failed");
		end
		$finish;
	end
endmodule
